[hw/rtl/dwps_pkg.sv]
// Shared types and constants for the dual wheel PI speed block.
// Used by the front decoder, the command queue, the back engine and the top level.
`default_nettype none

package dwps_pkg;

    // Input opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_GAIN_P       = 2'd0;
    localparam logic [1:0] REG_GAIN_I       = 2'd1;
    localparam logic [1:0] REG_DUTY_CEILING = 2'd2;
    localparam logic [1:0] REG_STALL_TICKS  = 2'd3;

    // Reset values of the configuration registers
    localparam logic [15:0] GAIN_P_RST       = 16'd2048;
    localparam logic [15:0] GAIN_I_RST       = 16'd2048;
    localparam logic [9:0]  DUTY_CEILING_RST = 10'd900;
    localparam logic [7:0]  STALL_TICKS_RST  = 8'd10;

    // Fixed-point constants
    localparam int              ACC_FRAC  = 18;
    localparam logic signed [15:0] ONE_SPEED = 16'sd16;
    localparam logic [7:0]      STALL_MAX = 8'd255;

    // Command queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_SET,
        CMD_CLEAR,
        CMD_IGNORE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               wheel;
        logic signed [15:0] target;
        logic signed [15:0] meas;
    } cmd_t;

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [9:0]  duty_ceiling;
        logic [7:0]  stall_ticks;
    } cfg_t;

    // Result item, out_wheel in bit 0
    typedef struct packed {
        logic       fault;
        logic       stop_all;
        logic [9:0] duty;
        logic       duty_write;
        logic       out_wheel;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC
    } back_state_t;

endpackage

`default_nettype wire

[hw/rtl/dwps_front.sv]
// Front end: accepts input requests and classifies them into queue commands.
// Depends on dwps_pkg.
`default_nettype none

module dwps_front #(
    parameter int WHEEL_COUNT = 2
) (
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [1:0]   s_tuser,   // opcode
    input  wire logic [39:0]  s_tdata,   // wheel, target_speed, measured_speed, pad
    input  wire logic         q_full,
    output logic              q_push,
    output dwps_pkg::cmd_t    q_cmd
);
    import dwps_pkg::*;

    logic wheel_ok;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign wheel_ok = 32'(s_tdata[0]) < WHEEL_COUNT;

    always_comb begin
        q_cmd.wheel  = s_tdata[0];
        q_cmd.target = s_tdata[16:1];
        q_cmd.meas   = s_tdata[32:17];
        unique case (s_tuser)
            OP_TICK:  q_cmd.kind = CMD_TICK;
            OP_SET:   q_cmd.kind = CMD_SET;
            OP_CLEAR: q_cmd.kind = CMD_CLEAR;
            default:  q_cmd.kind = CMD_IGNORE;
        endcase
        // mark requests for wheels that do not exist as ignored
        if (!wheel_ok) begin
            q_cmd.kind = CMD_IGNORE;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/dwps_queue.sv]
// Short command FIFO between the front decoder and the back engine.
// Depends on dwps_pkg.
`default_nettype none

module dwps_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire dwps_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output dwps_pkg::cmd_t      head_cmd
);
    import dwps_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = count_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_cmd  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/dwps_back.sv]
// Back engine: executes queued commands against the per-wheel PI state and
// drives the registered result channel. Depends on dwps_pkg.
`default_nettype none

module dwps_back #(
    parameter int WHEEL_COUNT = 2
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire dwps_pkg::cfg_t cfg,
    input  wire logic           q_valid,
    input  wire dwps_pkg::cmd_t q_cmd,
    output logic                q_pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [15:0]         m_tdata    // out_wheel, duty_write, duty[9:0], stop_all, fault
);
    import dwps_pkg::*;

    localparam int WIDX = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;

    // per-wheel state
    logic signed [15:0] target_reg [WHEEL_COUNT];
    logic [27:0]        acc_reg    [WHEEL_COUNT];
    logic signed [16:0] perr_reg   [WHEEL_COUNT];
    logic [7:0]         cnt_reg    [WHEEL_COUNT];
    logic               latch_reg;

    back_state_t state_reg, state_next;

    // tick pipeline
    cmd_t               cur_reg;
    logic signed [16:0] e_reg;
    logic signed [17:0] de_reg;
    logic signed [34:0] prod_p_reg;
    logic signed [33:0] prod_i_reg;

    logic               m_valid_reg;
    res_t               m_data_reg;

    logic [WIDX-1:0]    qidx;
    logic [WIDX-1:0]    cidx;
    logic               out_free;
    logic               tick_active;
    logic signed [16:0] e_next;
    logic signed [17:0] de_next;
    logic signed [34:0] prod_p_next;
    logic signed [33:0] prod_i_next;
    logic signed [35:0] delta_sum;
    logic signed [38:0] acc_sum;
    logic signed [38:0] acc_top;
    logic signed [38:0] acc_clamped;
    logic signed [10:0] ceil_m1;
    logic signed [38:0] acc_thr;
    logic [27:0]        acc_new;
    logic               stall_cond;
    logic [7:0]         cnt_inc;
    logic               trip;
    logic               res_load;
    res_t               res_next;
    logic               cnt_any;

    assign qidx     = WIDX'(q_cmd.wheel);
    assign cidx     = WIDX'(cur_reg.wheel);
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_data_reg};

    assign tick_active = (q_cmd.kind == CMD_TICK) && !latch_reg && (target_reg[qidx] != '0);
    assign e_next  = {target_reg[qidx][15], target_reg[qidx]} - {q_cmd.meas[15], q_cmd.meas};
    assign de_next = {e_next[16], e_next} - {perr_reg[qidx][16], perr_reg[qidx]};

    assign prod_p_next = $signed({1'b0, cfg.gain_p}) * de_reg;
    assign prod_i_next = $signed({1'b0, cfg.gain_i}) * e_reg;

    // accumulate, clamp to [0, ceiling] and test the stall threshold
    always_comb begin
        delta_sum = {prod_p_reg[34], prod_p_reg} + {{2{prod_i_reg[33]}}, prod_i_reg};
        acc_sum   = $signed({11'b0, acc_reg[cidx]}) + $signed({delta_sum[35], delta_sum, 2'b00});
        acc_top   = $signed({11'b0, cfg.duty_ceiling, 18'b0});
        if (acc_sum[38]) begin
            acc_clamped = '0;
        end else if (acc_sum > acc_top) begin
            acc_clamped = acc_top;
        end else begin
            acc_clamped = acc_sum;
        end
        acc_new    = acc_clamped[27:0];
        ceil_m1    = $signed({1'b0, cfg.duty_ceiling}) - 11'sd1;
        acc_thr    = $signed({{10{ceil_m1[10]}}, ceil_m1, 18'b0});
        stall_cond = (acc_clamped >= acc_thr) && ($signed(cur_reg.meas) < ONE_SPEED);
        cnt_inc    = (cnt_reg[cidx] == STALL_MAX) ? STALL_MAX : cnt_reg[cidx] + 8'd1;
        trip       = stall_cond && (cnt_inc >= cfg.stall_ticks);
    end

    always_comb begin
        cnt_any = 1'b0;
        for (int w = 0; w < WHEEL_COUNT; w++) begin
            cnt_any = cnt_any || (cnt_reg[w] != '0);
        end
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        res_load   = 1'b0;
        res_next   = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    if (tick_active) begin
                        state_next = ST_MUL;
                    end else begin
                        res_load            = 1'b1;
                        res_next.out_wheel  = q_cmd.wheel;
                        res_next.duty_write = (q_cmd.kind == CMD_SET) && (q_cmd.target == '0);
                        res_next.fault      = (q_cmd.kind == CMD_CLEAR) ? 1'b0 : latch_reg;
                    end
                end
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (out_free) begin
                    res_load            = 1'b1;
                    res_next.out_wheel  = cur_reg.wheel;
                    res_next.duty_write = 1'b1;
                    res_next.duty       = trip ? '0 : acc_new[27:ACC_FRAC];
                    res_next.stop_all   = trip;
                    res_next.fault      = trip || latch_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            latch_reg   <= 1'b0;
            for (int w = 0; w < WHEEL_COUNT; w++) begin
                target_reg[w] <= '0;
                acc_reg[w]    <= '0;
                perr_reg[w]   <= '0;
                cnt_reg[w]    <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                case (q_cmd.kind)
                    CMD_SET: begin
                        target_reg[qidx] <= q_cmd.target;
                        if (q_cmd.target == '0) begin
                            acc_reg[qidx]  <= '0;
                            perr_reg[qidx] <= '0;
                        end
                    end
                    CMD_CLEAR: begin
                        latch_reg <= 1'b0;
                        for (int w = 0; w < WHEEL_COUNT; w++) begin
                            cnt_reg[w] <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_ACC && out_free) begin
                if (trip) begin
                    latch_reg <= 1'b1;
                    for (int w = 0; w < WHEEL_COUNT; w++) begin
                        target_reg[w] <= '0;
                        acc_reg[w]    <= '0;
                        perr_reg[w]   <= '0;
                        cnt_reg[w]    <= '0;
                    end
                end else begin
                    acc_reg[cidx]  <= acc_new;
                    perr_reg[cidx] <= e_reg;
                    cnt_reg[cidx]  <= stall_cond ? cnt_inc : 8'd0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_data_reg <= res_next;
        end
        if (q_pop && tick_active) begin
            cur_reg <= q_cmd;
            e_reg   <= e_next;
            de_reg  <= de_next;
        end
        if (state_reg == ST_MUL) begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
        end
    end

    // a latched fault leaves every stall counter at zero
    a_latch_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        latch_reg |-> !cnt_any)
        else $error("stall counter nonzero while fault latched");

    a_mul_to_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |=> (state_reg == ST_ACC))
        else $error("multiply stage not followed by accumulate");

    a_acc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC && !out_free) |=> (state_reg == ST_ACC) && $stable(e_reg))
        else $error("accumulate stage lost its operands while stalled");

    a_stop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.stop_all) |->
            (m_data_reg.fault && m_data_reg.duty_write && (m_data_reg.duty == '0)))
        else $error("stop result without fault and zero duty");

endmodule

`default_nettype wire

[hw/rtl/dual_wheel_pi_speed_with_stall_trip.sv]
// Top level of the dual wheel PI speed controller with stall trip.
// Holds the APB register file; instantiates dwps_front, dwps_queue and dwps_back.
//
// Usage:
//   s_* channel: one request per handshake. s_tuser carries the opcode
//     (tick, set target, clear fault); s_tdata carries wheel and speeds.
//   m_* channel: exactly one result per request, in request order, from an
//     output register: wheel, duty_write, duty, stop_all, fault.
//   APB port: gain_p, gain_i, duty_ceiling, stall_ticks at 0x0/0x4/0x8/0xC.
//     Write only while no request is in flight.
// Result path, queue empty: set target, clear fault and inactive ticks go from
//   the queue head straight into the output register; an active tick first passes
//   its stages in order (queue and error, multiply, accumulate/clamp).
// The back engine takes its next command only when idle with the output register
//   free, after an active tick's multiply and accumulate states; the two-entry queue
//   lets the input side keep accepting while the engine works.
// Reset: targets, accumulators, errors, counters and the fault latch clear,
//   the registers take their reset values, the queue empties.
// Receiver stall: the result holds in the output register, the engine waits,
//   and requests back up into the queue until s_tready drops.
`default_nettype none

module dual_wheel_pi_speed_with_stall_trip #(
    parameter int WHEEL_COUNT = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode
    input  wire logic [39:0] s_tdata,   // [0] wheel, [16:1] target_speed,
                                        // [32:17] measured_speed, [39:33] zero
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [0] out_wheel, [1] duty_write, [11:2] duty,
                                        // [12] stop_all, [13] fault, [15:14] zero
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import dwps_pkg::*;

    cfg_t cfg_reg;
    logic cfg_write;
    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_not_empty;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // register writes, decoded on the word address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p       <= GAIN_P_RST;
            cfg_reg.gain_i       <= GAIN_I_RST;
            cfg_reg.duty_ceiling <= DUTY_CEILING_RST;
            cfg_reg.stall_ticks  <= STALL_TICKS_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_GAIN_P:       cfg_reg.gain_p       <= pwdata[15:0];
                REG_GAIN_I:       cfg_reg.gain_i       <= pwdata[15:0];
                REG_DUTY_CEILING: cfg_reg.duty_ceiling <= pwdata[9:0];
                REG_STALL_TICKS:  cfg_reg.stall_ticks  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // register reads, zero-extended
    always_comb begin
        unique case (paddr[3:2])
            REG_GAIN_P:       prdata = {16'b0, cfg_reg.gain_p};
            REG_GAIN_I:       prdata = {16'b0, cfg_reg.gain_i};
            REG_DUTY_CEILING: prdata = {22'b0, cfg_reg.duty_ceiling};
            REG_STALL_TICKS:  prdata = {24'b0, cfg_reg.stall_ticks};
            default:          prdata = '0;
        endcase
    end

    // classify requests
    dwps_front #(
        .WHEEL_COUNT (WHEEL_COUNT)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (front_cmd)
    );

    // decouple front and back
    dwps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // execute commands and drive results
    dwps_back #(
        .WHEEL_COUNT (WHEEL_COUNT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_not_empty),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the dual wheel PI speed controller with stall trip.
// Predicts every result in-line and drives the request, result and APB ports;
// depends on dwps_pkg and the dual_wheel_pi_speed_with_stall_trip top level.
`timescale 1ns / 1ps

module testbench;
    import dwps_pkg::*;

    // Opcode value the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles with no handshake on either channel before the run is declared hung
    localparam int IDLE_LIMIT = 2000;
    // Quiet cycles after the last result before touching registers or ending
    localparam int SETTLE_CYCLES = 8;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = OP_TICK;
    logic [39:0] s_tdata = '0;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    dual_wheel_pi_speed_with_stall_trip dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Speed loop predictor: its own copy of the wheel state and registers
    // ------------------------------------------------------------------
    logic signed [15:0] wheel_target [2];
    logic [27:0]        wheel_acc    [2];
    logic signed [16:0] wheel_err    [2];
    logic [7:0]         wheel_stall  [2];
    logic               trip_latched;

    logic [15:0] kp_gain;
    logic [15:0] ki_gain;
    logic [9:0]  duty_cap;
    logic [7:0]  trip_ticks;

    // Expected results, oldest first
    res_t duty_results_q[$];

    int error_count = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int trips_seen = 0;
    int settings_applied = 0;
    int burst_left = 1;

    function automatic void reset_speed_loop();
        for (int k = 0; k < 2; k++) begin
            wheel_target[k] = '0;
            wheel_acc[k]    = '0;
            wheel_err[k]    = '0;
            wheel_stall[k]  = '0;
        end
        trip_latched = 1'b0;
        kp_gain      = GAIN_P_RST;
        ki_gain      = GAIN_I_RST;
        duty_cap     = DUTY_CEILING_RST;
        trip_ticks   = STALL_TICKS_RST;
    endfunction

    // Advance the predicted state by one request and return its result
    function automatic res_t step_speed_loop(input logic [1:0] op, input logic w,
                                             input logic signed [15:0] tgt,
                                             input logic signed [15:0] meas);
        res_t   r;
        longint err, derr, acc, top, thr;
        r = '0;
        r.out_wheel = w;
        case (op)
            OP_SET: begin
                wheel_target[w] = tgt;
                // zero target drops the wheel's PI state and forces duty 0
                if (tgt == 0) begin
                    wheel_acc[w]  = '0;
                    wheel_err[w]  = '0;
                    r.duty_write  = 1'b1;
                end
            end
            OP_CLEAR: begin
                trip_latched = 1'b0;
                for (int k = 0; k < 2; k++) wheel_stall[k] = '0;
            end
            OP_TICK: begin
                if (!trip_latched && wheel_target[w] != 0) begin
                    err  = longint'(wheel_target[w]) - longint'(meas);
                    derr = err - longint'(wheel_err[w]);
                    // gain*error has 16 fraction bits; scale by 4 to reach 18
                    acc  = longint'(wheel_acc[w]) +
                           (longint'(kp_gain) * derr + longint'(ki_gain) * err) * 4;
                    top  = longint'(duty_cap) * (longint'(1) <<< ACC_FRAC);
                    thr  = top - (longint'(1) <<< ACC_FRAC);
                    if (acc < 0) acc = 0;
                    if (acc > top) acc = top;
                    wheel_acc[w] = acc[27:0];
                    wheel_err[w] = err[16:0];
                    if (acc >= thr && meas < ONE_SPEED) begin
                        if (wheel_stall[w] < STALL_MAX) wheel_stall[w] = wheel_stall[w] + 1'b1;
                        if (wheel_stall[w] >= trip_ticks) begin
                            for (int k = 0; k < 2; k++) begin
                                wheel_target[k] = '0;
                                wheel_acc[k]    = '0;
                                wheel_err[k]    = '0;
                                wheel_stall[k]  = '0;
                            end
                            trip_latched = 1'b1;
                            r.duty_write = 1'b1;
                            r.stop_all   = 1'b1;
                        end
                    end else begin
                        wheel_stall[w] = '0;
                    end
                    if (!r.stop_all) begin
                        r.duty_write = 1'b1;
                        r.duty       = acc[27:18];
                    end
                end
            end
            default: ;
        endcase
        r.fault = trip_latched;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one request, hold it until accepted, then record its prediction.
    // Valid stays high across a burst; between bursts drop it for a random gap.
    task automatic send_request(input logic [1:0] op, input logic w,
                                input logic signed [15:0] tgt,
                                input logic signed [15:0] meas);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, meas, tgt, w};
        do @(posedge aclk); while (!s_tready);
        duty_results_q.push_back(step_speed_loop(op, w, tgt, meas));
        requests_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                                      : $urandom_range(1, 10);
        end
    endtask

    // Hold off new requests until every expected result has come back,
    // then let the engine settle.
    task automatic wait_results_idle();
        s_tvalid <= 1'b0;
        while (duty_results_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        burst_left = $urandom_range(1, 10);
    endtask

    // ------------------------------------------------------------------
    // APB register access: write, then read back through the same select
    // ------------------------------------------------------------------
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // register takes the value at this edge; start the read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        check_field("register readback", value, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_GAIN_P:       kp_gain    = value[15:0];
            REG_GAIN_I:       ki_gain    = value[15:0];
            REG_DUTY_CEILING: duty_cap   = value[9:0];
            REG_STALL_TICKS:  trip_ticks = value[7:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Registers change only with the block idle: drain first (the sender
    // pauses here until every expected result has arrived).
    task automatic apply_settings(input logic [15:0] kp_v, input logic [15:0] ki_v,
                                  input logic [9:0] cap_v, input logic [7:0] trip_v);
        wait_results_idle();
        write_register(REG_GAIN_P, {16'd0, kp_v});
        write_register(REG_GAIN_I, {16'd0, ki_v});
        write_register(REG_DUTY_CEILING, {22'd0, cap_v});
        write_register(REG_STALL_TICKS, {24'd0, trip_v});
        settings_applied++;
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly ticks against live targets, plus stall runs
    // that drive the trip, with sets, clears and ignored opcodes mixed in
    // ------------------------------------------------------------------
    task automatic run_traffic(input int count);
        int                 sent, pick, off, run_len;
        logic               w;
        logic signed [15:0] tgt, meas;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            w    = 1'($urandom_range(0, 1));
            tgt  = 16'($urandom);
            meas = 16'($urandom);
            off  = $urandom_range(0, 64);
            if (trip_latched && $urandom_range(0, 3) != 0) begin
                // mostly release the latch so ticks reach the loop again
                send_request(OP_CLEAR, w, tgt, meas);
                sent++;
            end else if (pick < 60) begin
                case ($urandom_range(0, 4))
                    0: meas = 16'(int'(wheel_target[w]) + off - 32);
                    1: meas = 16'(off / 2 - 16);
                    2: meas = ($urandom_range(0, 1) != 0) ? 16'sd15 : 16'sd16;
                    3: ;
                    default: meas = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
                endcase
                send_request(OP_TICK, w, tgt, meas);
                sent++;
            end else if (pick < 80) begin
                case ($urandom_range(0, 3))
                    0: tgt = '0;
                    1: tgt = 16'($urandom_range(16, 2000));
                    2: tgt = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
                    default: ;
                endcase
                send_request(OP_SET, w, tgt, meas);
                sent++;
            end else if (pick < 86) begin
                send_request(OP_CLEAR, w, tgt, meas);
                sent++;
            end else if (pick < 92) begin
                send_request(OP_UNUSED, w, tgt, meas);
                sent++;
            end else begin
                // stall run: live target, output pinned high, wheel not moving
                if (trip_latched) begin
                    send_request(OP_CLEAR, w, tgt, meas);
                    sent++;
                end
                if (wheel_target[w] == 0) begin
                    send_request(OP_SET, w, 16'($urandom_range(8000, 32767)), meas);
                    sent++;
                end
                run_len = ($urandom_range(0, 29) == 0) ? int'(trip_ticks) + 2
                                                       : $urandom_range(2, 24);
                repeat (run_len) begin
                    off = $urandom_range(0, 31);
                    send_request(OP_TICK, w, 16'($urandom), 16'(off - 16));
                    sent++;
                end
            end
        end
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 8192));
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every opcode, zero target and ignored requests
    task automatic test_directed_fields();
        send_request(OP_SET,    1'b0, 16'sh7FFF, 16'sh0000);
        send_request(OP_TICK,   1'b0, 16'sh0000, 16'sh8000);
        send_request(OP_TICK,   1'b0, 16'shFFFF, 16'sh7FFF);
        send_request(OP_SET,    1'b1, 16'sh8000, 16'shFFFF);
        send_request(OP_TICK,   1'b1, 16'sh7FFF, 16'sh7FFF);
        send_request(OP_TICK,   1'b1, 16'sh0000, 16'sh0000);
        send_request(OP_UNUSED, 1'b0, 16'shFFFF, 16'shFFFF);
        send_request(OP_UNUSED, 1'b1, 16'sh5555, 16'shAAAA);
        send_request(OP_SET,    1'b0, 16'sh0000, 16'sh1234);
        send_request(OP_TICK,   1'b0, 16'sh4321, 16'sh0000);
        send_request(OP_CLEAR,  1'b1, 16'shAAAA, 16'sh5555);
    endtask

    // Stall trip at the reset threshold, then behavior while latched
    task automatic test_directed_stall();
        send_request(OP_SET, 1'b1, 16'sd32000, 16'sd0);
        repeat (int'(STALL_TICKS_RST)) send_request(OP_TICK, 1'b1, 16'sd0, 16'sd0);
        send_request(OP_TICK,  1'b0, 16'sd0,    16'sd0);
        send_request(OP_SET,   1'b0, 16'sd5000, 16'sd0);
        send_request(OP_TICK,  1'b0, 16'sd0,    16'sd3);
        send_request(OP_CLEAR, 1'b0, 16'sd0,    16'sd0);
    endtask

    // Extreme register settings, including a zero ceiling and a zero trip count
    task automatic test_settings_extremes();
        apply_settings(16'hFFFF, 16'hFFFF, 10'd1023, 8'd255);
        run_traffic(120);
        apply_settings(16'd0, 16'd0, 10'd1, 8'd1);
        run_traffic(120);
        apply_settings(16'd4096, 16'd0, 10'd1023, 8'd1);
        run_traffic(120);
        apply_settings(16'd0, 16'hFFFF, 10'd0, 8'd0);
        run_traffic(120);
    endtask

    task automatic test_random_settings();
        logic [9:0] cap_v;
        logic [7:0] trip_v;
        for (int phase = 0; phase < 5; phase++) begin
            case ($urandom_range(0, 2))
                0: cap_v = 10'd1;
                1: cap_v = 10'd1023;
                default: cap_v = 10'($urandom_range(1, 1023));
            endcase
            case ($urandom_range(0, 3))
                0: trip_v = 8'd1;
                1: trip_v = 8'd255;
                default: trip_v = 8'($urandom_range(1, 30));
            endcase
            apply_settings(pick_gain(), pick_gain(), cap_v, trip_v);
            run_traffic(190);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Receiver readiness changes mode every so often: always ready,
    // coin flip, or mostly stalled
    int       ready_stretch = 0;
    int       ready_mode = 0;

    always @(posedge aclk) begin
        if (ready_stretch == 0) begin
            ready_mode    <= $urandom_range(0, 2);
            ready_stretch <= $urandom_range(20, 200);
        end else begin
            ready_stretch <= ready_stretch - 1;
        end
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Compare each accepted result with the oldest expectation
    res_t seen_res;
    res_t want_res;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_res = res_t'(m_tdata[13:0]);
            if (duty_results_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got 0x%04h", $time, m_tdata);
                error_count++;
            end else begin
                want_res = duty_results_q.pop_front();
                check_field("out_wheel",  want_res.out_wheel,  seen_res.out_wheel);
                check_field("duty_write", want_res.duty_write, seen_res.duty_write);
                check_field("duty",       want_res.duty,       seen_res.duty);
                check_field("stop_all",   want_res.stop_all,   seen_res.stop_all);
                check_field("fault",      want_res.fault,      seen_res.fault);
                results_checked++;
                if (want_res.stop_all) trips_seen++;
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_speed_loop();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_fields();
        test_directed_stall();
        test_settings_extremes();
        test_random_settings();
        wait_results_idle();

        $display("Sent %0d requests under %0d register settings after reset defaults;",
                 requests_sent, settings_applied);
        $display("checked %0d results, %0d of them stall trips, %0d mismatches.",
                 results_checked, trips_seen, error_count);
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
